FILE: hdl/bgf_pkg.sv
// shared types, constants and tables of the battery gauge filter
`default_nettype none

package bgf_pkg;

	localparam int unsigned WINDOW_DEF   = 5;
	localparam int unsigned ADC_BITS_DEF = 10;

	localparam int unsigned TABLE_POINTS = 11;
	localparam int unsigned SEG_N        = TABLE_POINTS - 1;
	localparam int unsigned SEG_W        = $clog2(TABLE_POINTS);

	localparam int unsigned MV_W    = 14;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned ST_W    = 2;
	localparam int unsigned DEB_W   = 4;
	localparam int unsigned DIVP_W  = 7;
	localparam int unsigned ADCMV_W = 12;
	localparam int unsigned PROD_W  = MV_W + SEG_W + 1;
	localparam int unsigned DIV_NW  = PROD_W + PCT_W;
	localparam int unsigned DIV_DW  = MV_W + SEG_W;

	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	localparam logic [ADCMV_W-1:0] ADC_FULL_MV = 12'd3600;
	localparam logic [MV_W-1:0]    VOLT_CAP    = 14'd9000;
	localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;
	localparam logic [PCT_W-1:0]   PCT_MIN     = 7'd0;

	localparam logic [DIVP_W-1:0] DIVIDER_RST  = 7'd40;
	localparam logic [MV_W-1:0]   MIN_MV_RST   = 14'd3500;
	localparam logic [MV_W-1:0]   MAX_MV_RST   = 14'd4350;
	localparam logic [MV_W-1:0]   PRESENT_RST  = 14'd2000;
	localparam logic [PCT_W-1:0]  DONE_PCT_RST = 7'd98;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 4'd3;

	localparam logic [2:0] REG_DIVIDER  = 3'd0;
	localparam logic [2:0] REG_MIN_MV   = 3'd1;
	localparam logic [2:0] REG_MAX_MV   = 3'd2;
	localparam logic [2:0] REG_PRESENT  = 3'd3;
	localparam logic [2:0] REG_DONE_PCT = 3'd4;
	localparam logic [2:0] REG_DEBOUNCE = 3'd5;

	localparam logic [ST_W-1:0] ST_NO_BATT   = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_CONN  = 2'd1;
	localparam logic [ST_W-1:0] ST_CHARGING  = 2'd2;
	localparam logic [ST_W-1:0] ST_CHG_DONE  = 2'd3;

	localparam logic [MV_W-1:0] TBL_DIS [TABLE_POINTS] = '{
		14'd3300, 14'd3783, 14'd3843, 14'd3870, 14'd3885, 14'd3919,
		14'd3973, 14'd4024, 14'd4085, 14'd4179, 14'd4199
	};
	localparam logic [MV_W-1:0] TBL_CHG [TABLE_POINTS] = '{
		14'd3700, 14'd4000, 14'd4040, 14'd4070, 14'd4090, 14'd4110,
		14'd4125, 14'd4138, 14'd4145, 14'd4185, 14'd4210
	};

	typedef struct packed {
		logic [DIVP_W-1:0] divider_pct;
		logic [MV_W-1:0]   min_mv;
		logic [MV_W-1:0]   max_mv;
		logic [MV_W-1:0]   present_mv;
		logic [PCT_W-1:0]  done_pct;
		logic [DEB_W-1:0]  debounce_limit;
	} bgf_cfg_t;

	// packed so that filtered_mv lands in the lowest bits
	typedef struct packed {
		logic              shutdown_request;
		logic [ST_W-1:0]   status;
		logic [PCT_W-1:0]  level_pct;
		logic [MV_W-1:0]   filtered_mv;
	} bgf_res_t;

	typedef struct packed {
		logic ld_in;
		logic calc_mv;
		logic calc_num;
		logic div_start;
		logic take_vb;
		logic hist_upd;
		logic sum_acc;
		logic avg_ld;
		logic take_avg;
		logic lk_init;
		logic lk_step;
		logic lk_mul;
		logic lk_prep;
		logic take_pct;
		logic set_pct0;
		logic set_pct100;
		logic set_pct_seg;
		logic lk_next;
		logic out_load;
	} bgf_cmd_t;

	typedef struct packed {
		logic plug_change;
		logic sum_last;
		logic div_done;
		logic lk_low;
		logic lk_high;
		logic lk_hit;
		logic lk_flat;
		logic lk_last;
		logic pass;
	} bgf_sts_t;

	function automatic logic [MV_W-1:0] tbl_point(input logic chg, input logic [SEG_W-1:0] idx);
		logic [SEG_W-1:0] i;
		i = (idx > SEG_W'(SEG_N)) ? SEG_W'(SEG_N) : idx;
		return chg ? TBL_CHG[i] : TBL_DIS[i];
	endfunction

	// base percentage of a segment, a small constant table
	function automatic logic [PCT_W-1:0] seg_pct(input logic [SEG_W-1:0] idx);
		logic [PCT_W-1:0] p;
		p = '0;
		for (int k = 0; k <= SEG_N; k++) begin
			if (idx == SEG_W'(k)) begin
				p = PCT_W'((k * 100) / SEG_N);
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/battery_gauge_filter_lut_unit.sv
// battery gauge top level: register port, controller and datapath
// one sample at a time: a new sample is not accepted until the result has loaded
// next sample taken the cycle after the result loads
// up to four runs of the shared 26-bit divider, one history entry summed per cycle
// and up to ten segments searched per table lookup; a stalled output register adds its wait
// arst_n clears history, plug tracking, debounce, controller and registers to defaults
`default_nettype none

module battery_gauge_filter_lut_unit #(
	parameter int unsigned WINDOW   = bgf_pkg::WINDOW_DEF,
	parameter int unsigned ADC_BITS = bgf_pkg::ADC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bgf_pkg::PADDR_W-1:0]         paddr,
	input  logic [bgf_pkg::PDATA_W-1:0]         pwdata,
	output logic [bgf_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// adc_sample, ext_power
	input  logic [((ADC_BITS + 8) / 8) * 8-1:0] s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// filtered_mv, level_pct, status, shutdown_request
	output logic [$bits(bgf_pkg::bgf_res_t)-1:0] m_tdata
);

	import bgf_pkg::*;

	bgf_cfg_t cfg_q;
	bgf_cmd_t cmd;
	bgf_sts_t sts;
	bgf_res_t res;
	logic     wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.divider_pct    <= DIVIDER_RST;
			cfg_q.min_mv         <= MIN_MV_RST;
			cfg_q.max_mv         <= MAX_MV_RST;
			cfg_q.present_mv     <= PRESENT_RST;
			cfg_q.done_pct       <= DONE_PCT_RST;
			cfg_q.debounce_limit <= DEBOUNCE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DIVIDER:  cfg_q.divider_pct    <= pwdata[DIVP_W-1:0];
				REG_MIN_MV:   cfg_q.min_mv         <= pwdata[MV_W-1:0];
				REG_MAX_MV:   cfg_q.max_mv         <= pwdata[MV_W-1:0];
				REG_PRESENT:  cfg_q.present_mv     <= pwdata[MV_W-1:0];
				REG_DONE_PCT: cfg_q.done_pct       <= pwdata[PCT_W-1:0];
				REG_DEBOUNCE: cfg_q.debounce_limit <= pwdata[DEB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DIVIDER:  prdata = PDATA_W'(cfg_q.divider_pct);
			REG_MIN_MV:   prdata = PDATA_W'(cfg_q.min_mv);
			REG_MAX_MV:   prdata = PDATA_W'(cfg_q.max_mv);
			REG_PRESENT:  prdata = PDATA_W'(cfg_q.present_mv);
			REG_DONE_PCT: prdata = PDATA_W'(cfg_q.done_pct);
			REG_DEBOUNCE: prdata = PDATA_W'(cfg_q.debounce_limit);
			default:      prdata = '0;
		endcase
	end

	bgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bgf_dp #(
		.WINDOW   (WINDOW),
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg         (cfg_q),
		.adc_sample  (s_tdata[ADC_BITS-1:0]),
		.ext_power   (s_tdata[ADC_BITS]),
		.res         (res)
	);

	assign m_tdata = res;

endmodule

`default_nettype wire

FILE: hdl/bgf_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module bgf_div #(
	parameter int unsigned NW = bgf_pkg::DIV_NW,
	parameter int unsigned DW = bgf_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int unsigned CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    den_q;

	logic [DW:0]      shifted;
	logic [DW+1:0]    diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = ~diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

FILE: hdl/bgf_dp.sv
// datapath: scaling, moving average, table interpolation and status
`default_nettype none

module bgf_dp #(
	parameter int unsigned WINDOW   = bgf_pkg::WINDOW_DEF,
	parameter int unsigned ADC_BITS = bgf_pkg::ADC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bgf_pkg::bgf_cmd_t   cmd,
	output bgf_pkg::bgf_sts_t   sts,
	input  bgf_pkg::bgf_cfg_t   cfg,
	input  logic [ADC_BITS-1:0] adc_sample,
	input  logic                ext_power,
	output bgf_pkg::bgf_res_t   res
);

	import bgf_pkg::*;

	localparam int unsigned IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CW    = $clog2(WINDOW + 1);
	localparam int unsigned SW    = MV_W + $clog2(WINDOW + 1);
	localparam int unsigned MVP_W = ADC_BITS + ADCMV_W;

	logic [ADC_BITS-1:0] raw_q;
	logic                plug_q;
	logic [ADCMV_W-1:0]  mv_q;
	logic [DIV_NW-1:0]   num_q;
	logic [DIV_DW-1:0]   den_q;
	logic [MV_W-1:0]     vb_q;
	logic [MV_W-1:0]     hist_q [WINDOW];
	logic [IW-1:0]       wr_q;
	logic                full_q;
	logic                last_q;
	logic [IW-1:0]       k_q;
	logic [CW-1:0]       cnt_q;
	logic [SW-1:0]       sum_q;
	logic [MV_W-1:0]     filt_q;
	logic                shut_q;
	logic                pass_q;
	logic [MV_W-1:0]     v_q;
	logic [SEG_W-1:0]    seg_q;
	logic [PROD_W-1:0]   prod_q;
	logic [MV_W-1:0]     span_q;
	logic [PCT_W-1:0]    pct_q;
	logic [PCT_W-1:0]    level_q;
	logic [DEB_W-1:0]    deb_q;
	bgf_res_t            res_q;

	logic [MVP_W-1:0]    mvp;
	logic [DIVP_W-1:0]   div_eff;
	logic                div_done;
	logic [DIV_NW-1:0]   quo;
	logic [IW-1:0]       wr_nx;
	logic                full_nx;
	logic [CW-1:0]       cnt_nx;
	logic [MV_W-1:0]     clamp_v;
	logic                tsel;
	logic [MV_W-1:0]     t_lo;
	logic [MV_W-1:0]     t_hi;
	logic [MV_W-1:0]     t_first;
	logic [MV_W-1:0]     t_last;
	logic [ST_W-1:0]     st_nx;
	logic [DEB_W-1:0]    deb_nx;

	bgf_div #(
		.NW (DIV_NW),
		.DW (DIV_DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign mvp     = MVP_W'(raw_q) * MVP_W'(ADC_FULL_MV);
	assign div_eff = (cfg.divider_pct == '0) ? DIVP_W'(1) : cfg.divider_pct;

	assign wr_nx   = (wr_q == IW'(WINDOW - 1)) ? '0 : wr_q + IW'(1);
	assign full_nx = full_q | (wr_nx == '0);
	assign cnt_nx  = full_nx ? CW'(WINDOW) : CW'(wr_nx);

	always_comb begin
		if (filt_q < cfg.min_mv) begin
			clamp_v = cfg.min_mv;
		end else if (filt_q > cfg.max_mv) begin
			clamp_v = cfg.max_mv;
		end else begin
			clamp_v = filt_q;
		end
	end

	// first pass reads the level table, second the status table
	assign tsel    = plug_q ^ pass_q;
	assign t_lo    = tbl_point(tsel, seg_q);
	assign t_hi    = tbl_point(tsel, seg_q + SEG_W'(1));
	assign t_first = tbl_point(tsel, '0);
	assign t_last  = tbl_point(tsel, SEG_W'(SEG_N));

	always_comb begin
		st_nx  = ST_NOT_CONN;
		deb_nx = deb_q;
		if (filt_q < cfg.present_mv) begin
			st_nx  = ST_NO_BATT;
			deb_nx = '0;
		end else begin
			if (plug_q) begin
				if (deb_q < cfg.debounce_limit) begin
					deb_nx = deb_q + DEB_W'(1);
				end else begin
					st_nx = ST_CHARGING;
				end
			end else begin
				deb_nx = '0;
			end
			if (pct_q >= cfg.done_pct) begin
				st_nx = ST_CHG_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				hist_q[i] <= '0;
			end
			wr_q   <= '0;
			full_q <= 1'b0;
			last_q <= 1'b0;
			deb_q  <= '0;
			pass_q <= 1'b0;
		end else begin
			if (cmd.hist_upd) begin
				if (plug_q != last_q) begin
					for (int i = 0; i < WINDOW; i++) begin
						hist_q[i] <= vb_q;
					end
					wr_q   <= '0;
					full_q <= 1'b1;
					last_q <= plug_q;
				end else begin
					hist_q[wr_q] <= vb_q;
					wr_q         <= wr_nx;
					full_q       <= full_nx;
				end
			end
			if (cmd.ld_in) begin
				pass_q <= 1'b0;
			end else if (cmd.lk_next) begin
				pass_q <= 1'b1;
			end
			if (cmd.out_load) begin
				deb_q <= deb_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			raw_q  <= adc_sample;
			plug_q <= ext_power;
		end
		if (cmd.calc_mv) begin
			mv_q <= mvp[MVP_W-1:ADC_BITS];
		end
		if (cmd.calc_num) begin
			num_q <= DIV_NW'(mv_q) * DIV_NW'(PCT_MAX);
			den_q <= DIV_DW'(div_eff);
		end else if (cmd.avg_ld) begin
			num_q <= DIV_NW'(sum_q);
			den_q <= DIV_DW'(cnt_q);
		end else if (cmd.lk_prep) begin
			num_q <= DIV_NW'(prod_q) * DIV_NW'(PCT_MAX);
			den_q <= DIV_DW'(span_q) * DIV_DW'(SEG_N);
		end
		if (cmd.take_vb) begin
			vb_q <= (quo > DIV_NW'(VOLT_CAP)) ? VOLT_CAP : quo[MV_W-1:0];
		end
		if (cmd.hist_upd) begin
			sum_q <= '0;
			k_q   <= '0;
			cnt_q <= cnt_nx;
			if (plug_q != last_q) begin
				filt_q <= vb_q;
			end
		end else if (cmd.sum_acc) begin
			sum_q <= sum_q + SW'(hist_q[k_q]);
			k_q   <= k_q + IW'(1);
		end
		if (cmd.take_avg) begin
			filt_q <= quo[MV_W-1:0];
		end
		if (cmd.lk_init) begin
			seg_q <= '0;
			if (pass_q) begin
				v_q <= filt_q;
			end else begin
				v_q    <= clamp_v;
				shut_q <= (filt_q < cfg.min_mv) && !plug_q;
			end
		end else if (cmd.lk_step) begin
			seg_q <= seg_q + SEG_W'(1);
		end
		if (cmd.lk_mul) begin
			span_q <= t_hi - t_lo;
			prod_q <= PROD_W'(seg_q) * PROD_W'(t_hi - t_lo) + PROD_W'(v_q - t_lo);
		end
		if (cmd.take_pct) begin
			pct_q <= quo[PCT_W-1:0];
		end else if (cmd.set_pct0) begin
			pct_q <= PCT_MIN;
		end else if (cmd.set_pct100) begin
			pct_q <= PCT_MAX;
		end else if (cmd.set_pct_seg) begin
			pct_q <= seg_pct(seg_q);
		end
		if (cmd.lk_next) begin
			level_q <= pct_q;
		end
		if (cmd.out_load) begin
			res_q.filtered_mv      <= filt_q;
			res_q.level_pct        <= level_q;
			res_q.status           <= st_nx;
			res_q.shutdown_request <= shut_q;
		end
	end

	assign sts.plug_change = plug_q != last_q;
	assign sts.sum_last    = (CW'(k_q) + CW'(1)) == cnt_q;
	assign sts.div_done    = div_done;
	assign sts.lk_low      = v_q <= t_first;
	assign sts.lk_high     = v_q >= t_last;
	assign sts.lk_hit      = (v_q >= t_lo) && (v_q <= t_hi);
	assign sts.lk_flat     = t_hi == t_lo;
	assign sts.lk_last     = seg_q == SEG_W'(SEG_N - 1);
	assign sts.pass        = pass_q;

	assign res = res_q;

endmodule

`default_nettype wire

FILE: hdl/bgf_ctrl.sv
// controller: sequences one sample through the datapath
`default_nettype none

module bgf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  bgf_pkg::bgf_sts_t sts,
	output bgf_pkg::bgf_cmd_t cmd
);

	import bgf_pkg::*;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_MV        = 5'd1;
	localparam logic [4:0] S_NUM       = 5'd2;
	localparam logic [4:0] S_DVB_GO    = 5'd3;
	localparam logic [4:0] S_DVB_WAIT  = 5'd4;
	localparam logic [4:0] S_HIST      = 5'd5;
	localparam logic [4:0] S_SUM       = 5'd6;
	localparam logic [4:0] S_AVG_LD    = 5'd7;
	localparam logic [4:0] S_DAVG_GO   = 5'd8;
	localparam logic [4:0] S_DAVG_WAIT = 5'd9;
	localparam logic [4:0] S_LK_INIT   = 5'd10;
	localparam logic [4:0] S_LK_EDGE   = 5'd11;
	localparam logic [4:0] S_LK_SRCH   = 5'd12;
	localparam logic [4:0] S_LK_MUL    = 5'd13;
	localparam logic [4:0] S_LK_PREP   = 5'd14;
	localparam logic [4:0] S_DLK_GO    = 5'd15;
	localparam logic [4:0] S_DLK_WAIT  = 5'd16;
	localparam logic [4:0] S_LK_END    = 5'd17;
	localparam logic [4:0] S_OUT       = 5'd18;

	logic [4:0] state_q;
	logic [4:0] state_nx;
	logic       out_vld_q;
	logic       out_free;

	assign out_free = !out_vld_q || m_tready;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.ld_in = 1'b1;
					state_nx  = S_MV;
				end
			end
			S_MV: begin
				cmd.calc_mv = 1'b1;
				state_nx    = S_NUM;
			end
			S_NUM: begin
				cmd.calc_num = 1'b1;
				state_nx     = S_DVB_GO;
			end
			S_DVB_GO: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DVB_WAIT;
			end
			S_DVB_WAIT: begin
				if (sts.div_done) begin
					cmd.take_vb = 1'b1;
					state_nx    = S_HIST;
				end
			end
			S_HIST: begin
				cmd.hist_upd = 1'b1;
				state_nx     = sts.plug_change ? S_LK_INIT : S_SUM;
			end
			S_SUM: begin
				cmd.sum_acc = 1'b1;
				if (sts.sum_last) begin
					state_nx = S_AVG_LD;
				end
			end
			S_AVG_LD: begin
				cmd.avg_ld = 1'b1;
				state_nx   = S_DAVG_GO;
			end
			S_DAVG_GO: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DAVG_WAIT;
			end
			S_DAVG_WAIT: begin
				if (sts.div_done) begin
					cmd.take_avg = 1'b1;
					state_nx     = S_LK_INIT;
				end
			end
			S_LK_INIT: begin
				cmd.lk_init = 1'b1;
				state_nx    = S_LK_EDGE;
			end
			S_LK_EDGE: begin
				if (sts.lk_low) begin
					cmd.set_pct0 = 1'b1;
					state_nx     = S_LK_END;
				end else if (sts.lk_high) begin
					cmd.set_pct100 = 1'b1;
					state_nx       = S_LK_END;
				end else begin
					state_nx = S_LK_SRCH;
				end
			end
			S_LK_SRCH: begin
				if (sts.lk_hit) begin
					if (sts.lk_flat) begin
						cmd.set_pct_seg = 1'b1;
						state_nx        = S_LK_END;
					end else begin
						state_nx = S_LK_MUL;
					end
				end else if (sts.lk_last) begin
					cmd.set_pct100 = 1'b1;
					state_nx       = S_LK_END;
				end else begin
					cmd.lk_step = 1'b1;
				end
			end
			S_LK_MUL: begin
				cmd.lk_mul = 1'b1;
				state_nx   = S_LK_PREP;
			end
			S_LK_PREP: begin
				cmd.lk_prep = 1'b1;
				state_nx    = S_DLK_GO;
			end
			S_DLK_GO: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DLK_WAIT;
			end
			S_DLK_WAIT: begin
				if (sts.div_done) begin
					cmd.take_pct = 1'b1;
					state_nx     = S_LK_END;
				end
			end
			S_LK_END: begin
				if (sts.pass) begin
					state_nx = S_OUT;
				end else begin
					cmd.lk_next = 1'b1;
					state_nx    = S_LK_INIT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_vld_q;

endmodule

`default_nettype wire
